/* sv/dqap_pkg.sv */
// ----------------------------------------------------------------------------
// dqap_pkg
// Shared types and constants for the dotted-quad address parser: part phase
// codes, radix codes, the character class bundle and the result bundle.
// ----------------------------------------------------------------------------
package dqap_pkg;

  // part phase codes
  localparam logic [2:0] PH_START  = 3'd0;  // start of part
  localparam logic [2:0] PH_SPACE  = 3'd1;  // white space seen
  localparam logic [2:0] PH_SIGN   = 3'd2;  // sign seen
  localparam logic [2:0] PH_ZERO   = 3'd3;  // leading zero seen
  localparam logic [2:0] PH_HEXPFX = 3'd4;  // "0x" seen
  localparam logic [2:0] PH_DIGITS = 3'd5;  // in digits

  // radix codes
  localparam logic [1:0] BASE_DEC = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_BLANK = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // classification of one byte
  typedef struct packed {
    logic       is_dot;
    logic       is_blank;   // exactly 0x20
    logic       is_space;   // 0x20 or 0x09..0x0d
    logic       is_plus;
    logic       is_minus;
    logic       is_x;       // 'x' or 'X'
    logic       is_zero;    // '0'
    logic       oct_ok;
    logic       dec_ok;
    logic       hex_ok;
    logic [3:0] digit;      // digit value when hex_ok
  } char_class_t;

  // one result item
  typedef struct packed {
    logic [31:0] address;
    logic        status;
  } result_t;

endpackage

/* sv/dqap_char_decode.sv */
// ----------------------------------------------------------------------------
// dqap_char_decode
// Combinational classification of one string byte: separators, white space,
// sign, hex prefix letter and digit value with per-radix validity.
// ----------------------------------------------------------------------------
module dqap_char_decode (
  input  logic [7:0]                char_code_i,
  output dqap_pkg::char_class_t     class_o
);

  logic       is_num;
  logic       is_lower;
  logic       is_upper;
  logic [7:0] num_off;
  logic [7:0] lower_off;
  logic [7:0] upper_off;

  // digit ranges
  assign is_num   = (char_code_i >= 8'h30) && (char_code_i <= 8'h39);
  assign is_lower = (char_code_i >= 8'h61) && (char_code_i <= 8'h66);
  assign is_upper = (char_code_i >= 8'h41) && (char_code_i <= 8'h46);

  assign num_off   = char_code_i - 8'd48;
  assign lower_off = char_code_i - 8'd87;
  assign upper_off = char_code_i - 8'd55;

  // class bundle
  always_comb begin
    class_o.is_dot   = (char_code_i == dqap_pkg::CH_DOT);
    class_o.is_blank = (char_code_i == dqap_pkg::CH_BLANK);
    class_o.is_space = (char_code_i == dqap_pkg::CH_BLANK) ||
                       ((char_code_i >= 8'h09) && (char_code_i <= 8'h0D));
    class_o.is_plus  = (char_code_i == dqap_pkg::CH_PLUS);
    class_o.is_minus = (char_code_i == dqap_pkg::CH_MINUS);
    class_o.is_x     = (char_code_i == 8'h78) || (char_code_i == 8'h58);
    class_o.is_zero  = (char_code_i == 8'h30);
    class_o.oct_ok   = (char_code_i >= 8'h30) && (char_code_i <= 8'h37);
    class_o.dec_ok   = is_num;
    class_o.hex_ok   = is_num || is_lower || is_upper;
    if (is_lower) begin
      class_o.digit = lower_off[3:0];
    end else if (is_upper) begin
      class_o.digit = upper_off[3:0];
    end else begin
      class_o.digit = num_off[3:0];
    end
  end

endmodule

/* sv/dqap_parse_core.sv */
// ----------------------------------------------------------------------------
// dqap_parse_core
// Parse state of the current string. Each step applies one byte, or on the
// terminator forms the result and clears the state for the next string.
// ----------------------------------------------------------------------------
module dqap_parse_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            char_code_i,
  input  logic                  end_of_string_i,
  output logic                  res_valid_o,
  output dqap_pkg::result_t     res_o
);

  dqap_pkg::char_class_t cc;

  logic [31:0] sum_q,   sum_d;
  logic [31:0] mag_q,   mag_d;
  logic [1:0]  pnum_q,  pnum_d;
  logic [2:0]  phase_q, phase_d;
  logic [1:0]  base_q,  base_d;
  logic        minus_q, minus_d;
  logic        ovf_q,   ovf_d;
  logic        bad_q,   bad_d;
  logic        ign_q,   ign_d;
  logic [1:0]  seen_q,  seen_d;
  logic        fsp_q,   fsp_d;

  logic [35:0] mag_scaled;
  logic [35:0] mag_next;
  logic [31:0] part_val;
  logic [31:0] part_shifted;
  logic [31:0] sum_plus;
  logic        radix_ok;
  logic        do_dot;
  logic        do_add;
  logic        first_digit;

  dqap_char_decode u_decode (
    .char_code_i (char_code_i),
    .class_o     (cc)
  );

  // radix multiply-add for the next digit
  always_comb begin
    unique case (base_q)
      dqap_pkg::BASE_HEX: mag_scaled = {mag_q, 4'b0};
      dqap_pkg::BASE_OCT: mag_scaled = {1'b0, mag_q, 3'b0};
      default:            mag_scaled = {1'b0, mag_q, 3'b0} + {3'b0, mag_q, 1'b0};
    endcase
    unique case (base_q)
      dqap_pkg::BASE_HEX: radix_ok = cc.hex_ok;
      dqap_pkg::BASE_OCT: radix_ok = cc.oct_ok;
      default:            radix_ok = cc.dec_ok;
    endcase
  end

  assign mag_next = mag_scaled + {32'b0, cc.digit};

  // closing value of the current part, placed at its byte lane
  always_comb begin
    if (ovf_q) begin
      part_val = dqap_pkg::ALL_ONES;
    end else if (minus_q) begin
      part_val = 32'd0 - mag_q;
    end else begin
      part_val = mag_q;
    end
  end

  assign part_shifted = part_val << {pnum_q, 3'b0};
  assign sum_plus     = sum_q + part_shifted;

  // next state and result
  always_comb begin
    sum_d       = sum_q;
    mag_d       = mag_q;
    pnum_d      = pnum_q;
    phase_d     = phase_q;
    base_d      = base_q;
    minus_d     = minus_q;
    ovf_d       = ovf_q;
    bad_d       = bad_q;
    ign_d       = ign_q;
    seen_d      = seen_q;
    fsp_d       = fsp_q;
    do_dot      = 1'b0;
    do_add      = 1'b0;
    first_digit = 1'b0;
    res_valid_o = 1'b0;
    res_o.address = dqap_pkg::ALL_ONES;
    res_o.status  = 1'b1;

    if (step_i && !end_of_string_i) begin
      if (seen_q == 2'd0) begin
        fsp_d = cc.is_blank;
      end
      if (seen_q != 2'd2) begin
        seen_d = seen_q + 2'd1;
      end

      if (!bad_q && !ign_q) begin
        unique case (phase_q)
          dqap_pkg::PH_START, dqap_pkg::PH_SPACE: begin
            if (cc.is_dot && (phase_q == dqap_pkg::PH_START)) begin
              do_dot = 1'b1;
            end else if (cc.is_space) begin
              phase_d = dqap_pkg::PH_SPACE;
            end else if (cc.is_plus || cc.is_minus) begin
              minus_d = cc.is_minus;
              phase_d = dqap_pkg::PH_SIGN;
            end else begin
              first_digit = 1'b1;
            end
          end
          dqap_pkg::PH_SIGN: begin
            first_digit = 1'b1;
          end
          dqap_pkg::PH_ZERO: begin
            if (cc.is_x) begin
              phase_d = dqap_pkg::PH_HEXPFX;
            end else if (cc.is_dot) begin
              do_dot = 1'b1;
            end else if (cc.oct_ok) begin
              do_add  = 1'b1;
              phase_d = dqap_pkg::PH_DIGITS;
            end else begin
              bad_d = 1'b1;
            end
          end
          dqap_pkg::PH_HEXPFX: begin
            if (cc.hex_ok) begin
              base_d  = dqap_pkg::BASE_HEX;
              mag_d   = {28'b0, cc.digit};
              phase_d = dqap_pkg::PH_DIGITS;
            end else begin
              bad_d = 1'b1;
            end
          end
          dqap_pkg::PH_DIGITS: begin
            if (cc.is_dot) begin
              do_dot = 1'b1;
            end else if (radix_ok) begin
              do_add = 1'b1;
            end else begin
              bad_d = 1'b1;
            end
          end
          default: begin
            bad_d = 1'b1;
          end
        endcase

        // first character of the number picks the radix
        if (first_digit) begin
          if (cc.is_zero) begin
            base_d  = dqap_pkg::BASE_OCT;
            phase_d = dqap_pkg::PH_ZERO;
          end else if (cc.dec_ok) begin
            base_d  = dqap_pkg::BASE_DEC;
            mag_d   = {28'b0, cc.digit};
            phase_d = dqap_pkg::PH_DIGITS;
          end else begin
            bad_d = 1'b1;
          end
        end

        // accumulate with saturation
        if (do_add) begin
          if (mag_next[35:32] != 4'd0) begin
            ovf_d = 1'b1;
            mag_d = dqap_pkg::ALL_ONES;
          end else begin
            mag_d = mag_next[31:0];
          end
        end

        // close the part on a separator
        if (do_dot) begin
          sum_d = sum_plus;
          if (pnum_q == 2'd3) begin
            ign_d = 1'b1;
          end else begin
            pnum_d  = pnum_q + 2'd1;
            mag_d   = 32'd0;
            phase_d = dqap_pkg::PH_START;
            base_d  = dqap_pkg::BASE_DEC;
            minus_d = 1'b0;
            ovf_d   = 1'b0;
          end
        end
      end
    end else if (step_i) begin
      res_valid_o = 1'b1;
      priority if (seen_q == 2'd0) begin
        res_o.status = 1'b1;
      end else if ((seen_q == 2'd1) && fsp_q) begin
        res_o.address = 32'd0;
        res_o.status  = 1'b0;
      end else if (bad_q) begin
        res_o.status = 1'b1;
      end else if (ign_q) begin
        res_o.address = sum_q;
        res_o.status  = 1'b0;
      end else if ((phase_q == dqap_pkg::PH_START) || (phase_q == dqap_pkg::PH_ZERO) ||
                   (phase_q == dqap_pkg::PH_DIGITS)) begin
        res_o.address = sum_plus;
        res_o.status  = 1'b0;
      end else begin
        res_o.status = 1'b1;
      end

      // clear for the next string
      sum_d   = 32'd0;
      mag_d   = 32'd0;
      pnum_d  = 2'd0;
      phase_d = dqap_pkg::PH_START;
      base_d  = dqap_pkg::BASE_DEC;
      minus_d = 1'b0;
      ovf_d   = 1'b0;
      bad_d   = 1'b0;
      ign_d   = 1'b0;
      seen_d  = 2'd0;
      fsp_d   = 1'b0;
    end
  end

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= 32'd0;
      mag_q   <= 32'd0;
      pnum_q  <= 2'd0;
      phase_q <= dqap_pkg::PH_START;
      base_q  <= dqap_pkg::BASE_DEC;
      minus_q <= 1'b0;
      ovf_q   <= 1'b0;
      bad_q   <= 1'b0;
      ign_q   <= 1'b0;
      seen_q  <= 2'd0;
      fsp_q   <= 1'b0;
    end else begin
      sum_q   <= sum_d;
      mag_q   <= mag_d;
      pnum_q  <= pnum_d;
      phase_q <= phase_d;
      base_q  <= base_d;
      minus_q <= minus_d;
      ovf_q   <= ovf_d;
      bad_q   <= bad_d;
      ign_q   <= ign_d;
      seen_q  <= seen_d;
      fsp_q   <= fsp_d;
    end
  end

endmodule

/* sv/dotted_quad_address_parser_top.sv */
// ----------------------------------------------------------------------------
// dotted_quad_address_parser_top
// Parses a dotted-quad address string, one byte per transfer, into a 32-bit
// address and a status bit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries char_code_i and
//   end_of_string_i. Each byte of the string is one transfer; a transfer
//   with end_of_string_i high closes the string and yields one result.
//   Output channel (out_valid_o / out_ready_i) carries address_o and
//   status_o (0 parsed, 1 invalid with address all ones).
//   Throughput: one transfer per cycle unless a terminator waits. A byte
//   goes to the input register, then through the parse logic into the state
//   registers; out_valid_o rises from the result register after a terminator.
//   Stall: bytes keep flowing while a result waits; only a terminator waits
//   in the input register until the result register is free, which then
//   holds in_ready_o low.
//   Reset: clears the parse state and both valid flags; the first transfer
//   after reset starts a new string.
// ----------------------------------------------------------------------------
module dotted_quad_address_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_string_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] address_o,
  output logic        status_o
);

  logic              in_valid_q;
  logic [7:0]        in_char_q;
  logic              in_eos_q;
  logic              step;
  logic              res_valid;
  dqap_pkg::result_t res;
  logic              out_valid_q;
  dqap_pkg::result_t out_q;

  // input register advances unless a terminator meets a full result register
  assign step       = in_valid_q && (!in_eos_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_char_q <= char_code_i;
      in_eos_q  <= end_of_string_i;
    end
  end

  dqap_parse_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .char_code_i     (in_char_q),
    .end_of_string_i (in_eos_q),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign address_o   = out_q.address;
  assign status_o    = out_q.status;

`ifndef SYNTHESIS
  // a new result never overwrites one that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // results come only from a terminator leaving the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (in_valid_q && in_eos_q))
    else $error("result without terminator");

  // an invalid string reports all ones
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (address_o == dqap_pkg::ALL_ONES))
    else $error("invalid status with parsed address");
`endif

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dotted-quad address parser. A directed table of
// address strings is sent first, then random strings: mostly well-formed
// dotted quads with random radix, sign, white space and overflow, plus
// mutated and noise strings. Each byte is one transfer and a terminator
// transfer closes the string. Expected results come from the directed table
// where it gives them, else from a local model of the parser, and are matched
// in order against the output channel, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_ITEMS = 1600;
  localparam int MAX_GAP      = 12;
  localparam int HOLD_OFF     = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int TIMEOUT_NS   = 2_000_000;
  localparam int DIR_N        = 26;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [7:0]  char_code     = 8'h00;
  logic        end_of_string = 1'b0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [31:0] address;
  logic        status;

  dotted_quad_address_parser_top uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .char_code_i     (char_code),
    .end_of_string_i (end_of_string),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .address_o       (address),
    .status_o        (status)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // directed strings; '~' stands for byte 0x00
  string   dir_text  [DIR_N] = '{
    "", " ", "1.2.3.4", "255.255.255.255", "4294967295", "4294967296", "-1",
    "-99999999999", "0x7f.0.0.1", "010.0X1F.0xAbC.0XfF", "+5. -2. \t+0x10",
    "\011\012\013\014\0157", "1..3", ".", "....", "1.2.3.4.junk\377", "  ",
    "+", " -", "0x", "0X.1", "09", "12a", "1~", "1 .2", "0"
  };
  bit      dir_typed [DIR_N] = '{
    1, 1, 1, 1, 1, 1, 1, 0, 1, 0, 0, 0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1
  };
  dqap_pkg::result_t dir_want [DIR_N] = '{
    {dqap_pkg::ALL_ONES, 1'b1}, {32'h0, 1'b0}, {32'h0403_0201, 1'b0},
    {dqap_pkg::ALL_ONES, 1'b0}, {dqap_pkg::ALL_ONES, 1'b0},
    {dqap_pkg::ALL_ONES, 1'b0}, {dqap_pkg::ALL_ONES, 1'b0}, '0,
    {32'h0100_007F, 1'b0}, '0, '0, '0, '0, {32'h0, 1'b0}, {32'h0, 1'b0},
    {32'h0403_0201, 1'b0}, {dqap_pkg::ALL_ONES, 1'b1},
    {dqap_pkg::ALL_ONES, 1'b1}, {dqap_pkg::ALL_ONES, 1'b1},
    {dqap_pkg::ALL_ONES, 1'b1}, {dqap_pkg::ALL_ONES, 1'b1},
    {dqap_pkg::ALL_ONES, 1'b1}, {dqap_pkg::ALL_ONES, 1'b1},
    {dqap_pkg::ALL_ONES, 1'b1}, {dqap_pkg::ALL_ONES, 1'b1}, {32'h0, 1'b0}
  };

  dqap_pkg::result_t expected_addresses [$];
  logic [7:0]        text_q [$];
  int unsigned       items_sent;
  int unsigned       result_count = 0;
  int unsigned       error_count  = 0;
  bit                send_burst   = 1'b0;
  dqap_pkg::result_t want_r;

  // parser model state
  logic [31:0] pred_sum;
  logic [31:0] pred_mag;
  logic [2:0]  pred_idx;
  logic [2:0]  pred_phase;
  logic [1:0]  pred_radix;
  logic        pred_neg;
  logic        pred_sat;
  logic        pred_bad;
  logic        pred_skip;
  logic [1:0]  pred_seen;
  logic        pred_blank;

  function automatic logic [4:0] radix_value(input logic [1:0] b);
    case (b)
      dqap_pkg::BASE_HEX: return 5'd16;
      dqap_pkg::BASE_OCT: return 5'd8;
      default:            return 5'd10;
    endcase
  endfunction

  function automatic void start_part();
    pred_mag   = '0;
    pred_phase = dqap_pkg::PH_START;
    pred_radix = dqap_pkg::BASE_DEC;
    pred_neg   = 1'b0;
    pred_sat   = 1'b0;
  endfunction

  function automatic void clear_parse();
    start_part();
    pred_sum   = '0;
    pred_idx   = '0;
    pred_bad   = 1'b0;
    pred_skip  = 1'b0;
    pred_seen  = '0;
    pred_blank = 1'b0;
  endfunction

  // multiply-add one digit, saturating at all ones
  function automatic void add_digit(input logic [4:0] d);
    logic [63:0] t;
    t = {32'd0, pred_mag} * {59'd0, radix_value(pred_radix)} + {59'd0, d};
    if (t > {32'd0, dqap_pkg::ALL_ONES}) begin
      pred_sat = 1'b1;
      pred_mag = dqap_pkg::ALL_ONES;
    end else begin
      pred_mag = t[31:0];
    end
  endfunction

  // fold the current part into the address at its byte lane
  function automatic void close_part();
    logic [31:0] v;
    if (pred_sat) v = dqap_pkg::ALL_ONES;
    else if (pred_neg) v = -pred_mag;
    else v = pred_mag;
    pred_sum = pred_sum + (v << {pred_idx[1:0], 3'b000});
  endfunction

  function automatic void take_dot();
    close_part();
    if (pred_idx >= 3'd3) begin
      pred_skip = 1'b1;
    end else begin
      pred_idx = pred_idx + 3'd1;
      start_part();
    end
  endfunction

  function automatic void predict_byte(input logic [7:0] c);
    logic [4:0] d;
    if (c >= "0" && c <= "9") d = {1'b0, c[3:0]};
    else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) d = {1'b0, c[3:0]} + 5'd9;
    else d = 5'd16;
    if (pred_seen == 2'd0) pred_blank = (c == dqap_pkg::CH_BLANK);
    if (pred_seen < 2'd2) pred_seen = pred_seen + 2'd1;
    if (pred_bad || pred_skip) return;
    case (pred_phase)
      dqap_pkg::PH_START, dqap_pkg::PH_SPACE, dqap_pkg::PH_SIGN: begin
        if (pred_phase == dqap_pkg::PH_START && c == dqap_pkg::CH_DOT) begin
          take_dot();
        end else if (pred_phase != dqap_pkg::PH_SIGN &&
                     (c == dqap_pkg::CH_BLANK || (c >= 8'h09 && c <= 8'h0D))) begin
          pred_phase = dqap_pkg::PH_SPACE;
        end else if (pred_phase != dqap_pkg::PH_SIGN &&
                     (c == dqap_pkg::CH_PLUS || c == dqap_pkg::CH_MINUS)) begin
          pred_neg   = (c == dqap_pkg::CH_MINUS);
          pred_phase = dqap_pkg::PH_SIGN;
        end else if (d == 5'd0) begin
          pred_radix = dqap_pkg::BASE_OCT;
          pred_phase = dqap_pkg::PH_ZERO;
        end else if (d <= 5'd9) begin
          pred_radix = dqap_pkg::BASE_DEC;
          pred_mag   = {27'd0, d};
          pred_phase = dqap_pkg::PH_DIGITS;
        end else begin
          pred_bad = 1'b1;
        end
      end
      dqap_pkg::PH_ZERO: begin
        if (c == "x" || c == "X") pred_phase = dqap_pkg::PH_HEXPFX;
        else if (c == dqap_pkg::CH_DOT) take_dot();
        else if (d <= 5'd7) begin
          add_digit(d);
          pred_phase = dqap_pkg::PH_DIGITS;
        end else pred_bad = 1'b1;
      end
      dqap_pkg::PH_HEXPFX: begin
        if (d < 5'd16) begin
          pred_radix = dqap_pkg::BASE_HEX;
          pred_mag   = {27'd0, d};
          pred_phase = dqap_pkg::PH_DIGITS;
        end else pred_bad = 1'b1;
      end
      dqap_pkg::PH_DIGITS: begin
        if (c == dqap_pkg::CH_DOT) take_dot();
        else if (d < radix_value(pred_radix)) add_digit(d);
        else pred_bad = 1'b1;
      end
      default: pred_bad = 1'b1;
    endcase
  endfunction

  function automatic dqap_pkg::result_t predict_terminator();
    dqap_pkg::result_t r;
    r.address = dqap_pkg::ALL_ONES;
    r.status  = 1'b1;
    if (pred_seen == 2'd1 && pred_blank) begin
      r.address = '0;
      r.status  = 1'b0;
    end else if (pred_seen != 2'd0 && !pred_bad) begin
      if (pred_skip) begin
        r.address = pred_sum;
        r.status  = 1'b0;
      end else if (pred_phase == dqap_pkg::PH_START || pred_phase == dqap_pkg::PH_ZERO ||
                   pred_phase == dqap_pkg::PH_DIGITS) begin
        close_part();
        r.address = pred_sum;
        r.status  = 1'b0;
      end
    end
    clear_parse();
    return r;
  endfunction

  // one input transfer after a random gap
  task automatic send_transfer(input logic [7:0] c, input logic eos);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    char_code     <= c;
    end_of_string <= eos;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // send text_q and its terminator, then queue the expected address
  task automatic send_text(input bit typed, input dqap_pkg::result_t want);
    dqap_pkg::result_t predicted;
    foreach (text_q[i]) begin
      predict_byte(text_q[i]);
      send_transfer(text_q[i], 1'b0);
    end
    predicted = predict_terminator();
    send_transfer(8'($urandom_range(0, 255)), 1'b1);
    expected_addresses.push_back(typed ? want : predicted);
  endtask

  // random address string, mostly well formed
  task automatic build_random_text();
    int unsigned kind;
    int unsigned parts;
    int unsigned style;
    int unsigned ndig;
    int unsigned d;
    bit          big;
    text_q.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(0, 10)) text_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    parts = $urandom_range(1, 4);
    for (int p = 0; p < parts; p++) begin
      if (p != 0) text_q.push_back(dqap_pkg::CH_DOT);
      style = $urandom_range(0, 15);
      big   = ($urandom_range(0, 19) == 0);
      // style zero leaves the part empty
      if (style != 0) begin
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 2)) begin
            if ($urandom_range(0, 1) != 0) text_q.push_back(dqap_pkg::CH_BLANK);
            else text_q.push_back(8'(8'h09 + $urandom_range(0, 4)));
          end
        end
        case ($urandom_range(0, 9))
          0: text_q.push_back(dqap_pkg::CH_PLUS);
          1: text_q.push_back(dqap_pkg::CH_MINUS);
          default: ;
        endcase
        case (style % 3)
          0: begin
            ndig = big ? $urandom_range(10, 12) : $urandom_range(1, 3);
            text_q.push_back(8'("0" + $urandom_range(1, 9)));
            repeat (ndig - 1) text_q.push_back(8'("0" + $urandom_range(0, 9)));
          end
          1: begin
            ndig = big ? $urandom_range(11, 12) : $urandom_range(0, 3);
            text_q.push_back("0");
            repeat (ndig) text_q.push_back(8'("0" + $urandom_range(0, 7)));
          end
          default: begin
            ndig = big ? $urandom_range(9, 10) : $urandom_range(1, 2);
            text_q.push_back("0");
            text_q.push_back(($urandom_range(0, 1) != 0) ? "x" : "X");
            repeat (ndig) begin
              d = $urandom_range(0, 15);
              if (d < 10) text_q.push_back(8'("0" + d));
              else if ($urandom_range(0, 1) != 0) text_q.push_back(8'("a" + d - 10));
              else text_q.push_back(8'("A" + d - 10));
            end
          end
        endcase
      end
    end
    // trailing bytes past the fourth dot
    if (parts == 4 && $urandom_range(0, 3) == 0) begin
      text_q.push_back(dqap_pkg::CH_DOT);
      repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom_range(0, 255)));
    end
    // broken strings: one byte replaced, or the tail cut
    if (kind == 1 && text_q.size() != 0)
      text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
    else if (kind == 2 && text_q.size() != 0)
      void'(text_q.pop_back());
  endtask

  // sender: reset, directed table, random strings, drain and verdict
  initial begin
    logic [7:0] b;
    clear_parse();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int r = 0; r < DIR_N; r++) begin
      text_q.delete();
      for (int i = 0; i < dir_text[r].len(); i++) begin
        b = dir_text[r].getc(i);
        if (b == "~") b = 8'h00;
        text_q.push_back(b);
      end
      send_burst = ($urandom_range(0, 3) == 0);
      send_text(dir_typed[r], dir_want[r]);
    end
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      build_random_text();
      send_burst = ($urandom_range(0, 7) == 0);
      send_text(1'b0, '0);
    end
    in_valid <= 1'b0;
    while (expected_addresses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_addresses.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // receiver: random stalls, bursts, and one long hold-off
  initial begin
    int unsigned hold;
    int unsigned burst_left;
    bit          held_off;
    burst_left = 0;
    held_off   = 1'b0;
    @(posedge clk);
    forever begin
      if (!held_off && result_count >= 40) begin
        hold     = HOLD_OFF;
        held_off = 1'b1;
      end else if (burst_left != 0) begin
        hold = 0;
        burst_left--;
      end else begin
        hold = $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(8, 24);
      end
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // compare each output transfer with the oldest expected address
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      result_count++;
      if (expected_addresses.size() == 0) begin
        $display("%0t ns: expected no result, actual address %08h status %0d",
                 $time, address, status);
        error_count++;
      end else begin
        want_r = expected_addresses.pop_front();
        if (address !== want_r.address) begin
          $display("%0t ns: address expected %08h actual %08h",
                   $time, want_r.address, address);
          error_count++;
        end
        if (status !== want_r.status) begin
          $display("%0t ns: status expected %0d actual %0d",
                   $time, want_r.status, status);
          error_count++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
